// File: src/twd_pkg.sv
package twd_pkg;

  localparam int TAG_W = 16;
  localparam int WORKER_W = 3;
  localparam int LOAD_W = 7;
  localparam int LVL_W = 3;
  localparam int STEP_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam int DEF_NUM_WORKERS = 8;
  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int MAX_LOAD = 105;

  localparam logic [LVL_W-1:0] LEVEL_COUNT_RST = 3'd3;
  localparam logic [STEP_W-1:0] LEVEL_STEP_RST = 4'd5;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP = 2'd1;

  localparam logic [1:0] OP_POST = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_ASSIGN = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_DISP = 4'd1;
  localparam logic [PC_W-1:0] PC_POST = 4'd2;
  localparam logic [PC_W-1:0] PC_FIN = 4'd3;
  localparam logic [PC_W-1:0] PC_TINIT = 4'd4;
  localparam logic [PC_W-1:0] PC_CHK = 4'd5;
  localparam logic [PC_W-1:0] PC_LOAD = 4'd6;
  localparam logic [PC_W-1:0] PC_ADV = 4'd7;
  localparam logic [PC_W-1:0] PC_END = 4'd8;
  localparam logic [PC_W-1:0] PC_READ = 4'd9;
  localparam logic [PC_W-1:0] PC_ASSIGN = 4'd10;

  localparam logic [2:0] C_NEXT = 3'd0;
  localparam logic [2:0] C_ALWAYS = 3'd1;
  localparam logic [2:0] C_NOFIRE = 3'd2;
  localparam logic [2:0] C_DISPATCH = 3'd3;
  localparam logic [2:0] C_NOPEND = 3'd4;
  localparam logic [2:0] C_EMPTY = 3'd5;
  localparam logic [2:0] C_LOADOK = 3'd6;
  localparam logic [2:0] C_NOTLAST = 3'd7;

  localparam logic [2:0] A_NOP = 3'd0;
  localparam logic [2:0] A_LATCH = 3'd1;
  localparam logic [2:0] A_POST = 3'd2;
  localparam logic [2:0] A_FINISH = 3'd3;
  localparam logic [2:0] A_TINIT = 3'd4;
  localparam logic [2:0] A_ADV = 3'd5;
  localparam logic [2:0] A_POP = 3'd6;
  localparam logic [2:0] A_HOLD = 3'd7;

  typedef struct packed {
    logic [2:0] cond;
    logic [PC_W-1:0] tgt;
    logic [2:0] act;
    logic flush;
  } uword_t;

  typedef struct packed {
    logic in_fire;
    logic [1:0] op;
    logic nopend;
    logic empty;
    logic load_ok;
    logic notlast;
    logic stall;
  } flags_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{cond: C_ALWAYS, tgt: PC_IDLE, act: A_NOP, flush: 1'b0};
    unique case (pc)
      PC_IDLE: w = '{cond: C_NOFIRE, tgt: PC_IDLE, act: A_LATCH, flush: 1'b0};
      PC_DISP: w = '{cond: C_DISPATCH, tgt: PC_IDLE, act: A_NOP, flush: 1'b0};
      PC_POST: w = '{cond: C_ALWAYS, tgt: PC_IDLE, act: A_POST, flush: 1'b0};
      PC_FIN: w = '{cond: C_ALWAYS, tgt: PC_IDLE, act: A_FINISH, flush: 1'b0};
      PC_TINIT: w = '{cond: C_NOPEND, tgt: PC_END, act: A_TINIT, flush: 1'b0};
      PC_CHK: w = '{cond: C_EMPTY, tgt: PC_END, act: A_NOP, flush: 1'b0};
      PC_LOAD: w = '{cond: C_LOADOK, tgt: PC_READ, act: A_NOP, flush: 1'b0};
      PC_ADV: w = '{cond: C_NOTLAST, tgt: PC_CHK, act: A_ADV, flush: 1'b0};
      PC_END: w = '{cond: C_ALWAYS, tgt: PC_IDLE, act: A_NOP, flush: 1'b1};
      PC_READ: w = '{cond: C_NEXT, tgt: PC_IDLE, act: A_POP, flush: 1'b0};
      PC_ASSIGN: w = '{cond: C_ALWAYS, tgt: PC_CHK, act: A_HOLD, flush: 1'b0};
      default: w = '{cond: C_ALWAYS, tgt: PC_IDLE, act: A_NOP, flush: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: src/twd_ram.sv
module twd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/twd_seq.sv
module twd_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  twd_pkg::flags_t flags,
  output twd_pkg::uword_t uw
);
  import twd_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic [PC_W-1:0] pc_inc;
  logic [PC_W-1:0] disp_tgt;

  assign uw = ucode(pc_r);
  assign pc_inc = pc_r + PC_W'(1);

  always_comb begin
    unique case (flags.op)
      OP_POST: disp_tgt = PC_POST;
      OP_FINISH: disp_tgt = PC_FIN;
      OP_TICK: disp_tgt = PC_TINIT;
      default: disp_tgt = PC_IDLE;
    endcase
  end

  always_comb begin
    pc_nxt = pc_inc;
    if (flags.stall) begin
      pc_nxt = pc_r;
    end else begin
      unique case (uw.cond)
        C_NEXT: pc_nxt = pc_inc;
        C_ALWAYS: pc_nxt = uw.tgt;
        C_NOFIRE: pc_nxt = flags.in_fire ? pc_inc : uw.tgt;
        C_DISPATCH: pc_nxt = disp_tgt;
        C_NOPEND: pc_nxt = flags.nopend ? uw.tgt : pc_inc;
        C_EMPTY: pc_nxt = flags.empty ? uw.tgt : pc_inc;
        C_LOADOK: pc_nxt = flags.load_ok ? uw.tgt : pc_inc;
        C_NOTLAST: pc_nxt = flags.notlast ? uw.tgt : pc_inc;
        default: pc_nxt = PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: src/tiered_worker_dispatcher_core.sv
// Job dispatcher with a pending tag queue and one load counter per worker.
// Input channel (in_valid/in_ready): op 0 posts in_job_tag to the queue, op 1
// reports that worker in_worker_index finished a job, op 2 is a dispatch tick.
// Result channel (out_valid/out_ready) carries assignments, completion reports
// and queue-full rejections; out_last marks the final result of an item.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set the round count and
// the per-round load step; the user must make them only while no item is in flight.
// The block does not enforce this. A post or a finish runs the idle, dispatch
// and post or finish steps, and its report or rejection is registered on the
// output. A tick runs the tick-init step, then per worker visit the check and
// load steps, with read and assign steps per assignment and the advance step
// once the worker is at its ceiling; the end step closes the tick. The control
// program spends one step per cycle unless stalled; the tag queue read is registered.
// Each assignment is held back one step so that the final one can carry last.
// Reset empties the queue, clears all loads and restores the register defaults.
// When the receiver stalls, the control program waits at the step that needs
// the output register, and no new item is taken until that item is finished.
module tiered_worker_dispatcher_core #(
  parameter int NUM_WORKERS = twd_pkg::DEF_NUM_WORKERS,
  parameter int QUEUE_DEPTH = twd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [twd_pkg::TAG_W-1:0]      in_job_tag,
  input  logic [twd_pkg::WORKER_W-1:0]   in_worker_index,
  input  logic                           in_finish_ok,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [twd_pkg::TAG_W-1:0]      out_tag,
  output logic [twd_pkg::WORKER_W-1:0]   out_worker,
  output logic                           out_ok,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [twd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import twd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WK_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [WK_W-1:0] WK_MAX = WK_W'(NUM_WORKERS - 1);
  localparam logic [WORKER_W:0] NW = (WORKER_W + 1)'(NUM_WORKERS);

  uword_t uw;
  flags_t flags;

  logic [LVL_W-1:0] level_count_r;
  logic [STEP_W-1:0] level_step_r;

  logic [1:0] op_r;
  logic [TAG_W-1:0] tag_r;
  logic [WORKER_W-1:0] widx_r;
  logic ok_r;

  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] tail_r;
  logic [CNT_W-1:0] count_r;
  logic [LOAD_W-1:0] load_r [NUM_WORKERS];

  logic [LVL_W-1:0] lvl_r;
  logic [LOAD_W-1:0] ceil_r;
  logic [WK_W-1:0] wk_r;

  logic hold_vld_r;
  logic [TAG_W-1:0] hold_tag_r;
  logic [WK_W-1:0] hold_wk_r;

  logic out_valid_r;
  logic [1:0] out_kind_r;
  logic [TAG_W-1:0] out_tag_r;
  logic [WORKER_W-1:0] out_worker_r;
  logic out_ok_r;
  logic out_last_r;

  logic [TAG_W-1:0] ram_rdata;
  logic out_free;
  logic full;
  logic need_out;
  logic go;
  logic do_push;
  logic do_pop;
  logic do_fin_dec;
  logic fin_in_range;
  logic in_fire;
  logic emit;
  logic [1:0] emit_kind;
  logic [TAG_W-1:0] emit_tag;
  logic [WORKER_W-1:0] emit_worker;
  logic emit_ok;
  logic emit_last;

  assign in_ready = (uw.act == A_LATCH);
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign full = (count_r == CNT_FULL);
  assign fin_in_range = ({1'b0, widx_r} < NW);

  always_comb begin
    need_out = 1'b0;
    if (uw.flush) begin
      need_out = hold_vld_r;
    end else begin
      unique case (uw.act)
        A_POST: need_out = full;
        A_FINISH: need_out = 1'b1;
        A_HOLD: need_out = hold_vld_r;
        default: need_out = 1'b0;
      endcase
    end
  end

  assign flags.stall = need_out && !out_free;
  assign go = !flags.stall;
  assign flags.in_fire = in_fire;
  assign flags.op = op_r;
  assign flags.nopend = (count_r == '0) || (level_count_r == '0);
  assign flags.empty = (count_r == '0);
  assign flags.load_ok = (load_r[wk_r] < ceil_r);
  assign flags.notlast = !((wk_r == WK_MAX) && (lvl_r == level_count_r));

  twd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uw    (uw)
  );

  assign do_push = (uw.act == A_POST) && !full;
  assign do_pop = (uw.act == A_POP);
  assign do_fin_dec = (uw.act == A_FINISH) && go && fin_in_range;

  twd_ram #(
    .WIDTH (TAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail_r),
    .wdata (tag_r),
    .re    (do_pop),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    emit = need_out && go;
    emit_kind = KIND_ASSIGN;
    emit_tag = hold_tag_r;
    emit_worker = WORKER_W'(hold_wk_r);
    emit_ok = 1'b0;
    emit_last = 1'b0;
    if (uw.flush) begin
      emit_last = 1'b1;
    end else if (uw.act == A_POST) begin
      emit_kind = KIND_REJECT;
      emit_tag = tag_r;
      emit_worker = '0;
      emit_last = 1'b1;
    end else if (uw.act == A_FINISH) begin
      emit_kind = KIND_REPORT;
      emit_tag = tag_r;
      emit_worker = widx_r;
      emit_ok = ok_r;
      emit_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LEVEL_COUNT_RST;
      level_step_r <= LEVEL_STEP_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_LEVEL_COUNT) begin
        level_count_r <= cfg_wdata[LVL_W-1:0];
      end else if (cfg_index == REG_LEVEL_STEP) begin
        level_step_r <= cfg_wdata[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_op;
      tag_r <= in_job_tag;
      widx_r <= in_worker_index;
      ok_r <= in_finish_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        tail_r <= (tail_r == PTR_MAX) ? '0 : tail_r + PTR_W'(1);
        count_r <= count_r + CNT_W'(1);
      end
      if (do_pop) begin
        head_r <= (head_r == PTR_MAX) ? '0 : head_r + PTR_W'(1);
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORKERS; i++) begin
        load_r[i] <= '0;
      end
    end else begin
      if (do_pop) begin
        load_r[wk_r] <= load_r[wk_r] + LOAD_W'(1);
      end
      if (do_fin_dec && (load_r[widx_r[WK_W-1:0]] != '0)) begin
        load_r[widx_r[WK_W-1:0]] <= load_r[widx_r[WK_W-1:0]] - LOAD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
      ceil_r <= '0;
      wk_r <= '0;
    end else if (uw.act == A_TINIT) begin
      lvl_r <= LVL_W'(1);
      ceil_r <= LOAD_W'(level_step_r);
      wk_r <= '0;
    end else if ((uw.act == A_ADV) && flags.notlast) begin
      if (wk_r == WK_MAX) begin
        wk_r <= '0;
        lvl_r <= lvl_r + LVL_W'(1);
        ceil_r <= ceil_r + LOAD_W'(level_step_r);
      end else begin
        wk_r <= wk_r + WK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (go) begin
      if (uw.flush) begin
        hold_vld_r <= 1'b0;
      end else if (uw.act == A_HOLD) begin
        hold_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && (uw.act == A_HOLD)) begin
      hold_tag_r <= ram_rdata;
      hold_wk_r <= wk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_tag_r <= emit_tag;
      out_worker_r <= emit_worker;
      out_ok_r <= emit_ok;
      out_last_r <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_tag = out_tag_r;
  assign out_worker = out_worker_r;
  assign out_ok = out_ok_r;
  assign out_last = out_last_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("Queue count exceeds its depth.");

  a_hold_empty_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !hold_vld_r)
    else $error("A held assignment survived the end of its tick.");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> (count_r != '0) && flags.load_ok)
    else $error("Queue popped while empty or worker at its ceiling.");

  a_load_bound : assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> (load_r[wk_r] < LOAD_W'(MAX_LOAD)))
    else $error("Worker load would pass its largest ceiling.");

endmodule
